@@ hw/rtl/sorted_record_table_assert.svh @@
// Assertion macros for the sorted record table.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH
`define SRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/srt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;
   localparam int TableDepthDefault = 64;
   localparam int NameCharsDefault  = 8;
   localparam int IdW   = 48;
   localparam int NameW = 64;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0, OP_REMOVE = 2'd1, OP_LOOKUP = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SCAN, S_DONE
   } state_type;

   function automatic logic [NameW-1:0] clip_word(input logic [NameW-1:0] w,
                                                  input int nbytes);
      logic ended;
      logic [NameW-1:0] r;
      ended = 1'b0;
      r = '0;
      for (int k = 7; k >= 0; k--) begin
         if (k < nbytes) begin
            if (w[8*k +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[8*k +: 8] = w[8*k +: 8];
         end
      end
      return r;
   endfunction
endpackage

@@ hw/rtl/sorted_record_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table
// Sorted record table: insert, remove and lookup over one memory.
// ----------------------------------------------------------------------------
// Records sit in one synchronous memory in ascending (given, family) order.
// Each request walks the memory one slot per cycle: an insert walks down from
// the top moving records up until its place, a remove or lookup walks up from
// slot 0, a remove moving each later record down. The walk is paced by the
// single memory port pair, one read and one write per cycle. The result waits
// in an output register; the next request is taken once it has been delivered.
module sorted_record_table #(
   parameter int TABLE_DEPTH = srt_pkg::TableDepthDefault,
   parameter int NAME_CHARS  = srt_pkg::NameCharsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [183:0] req_tdata,  // op[1:0], rec_id[49:2], given_name[113:50],
                                    // family_name[177:114], gender[178], zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata   // status[1:0], slot[7:2], entry_count[14:8],
                                    // issued_count[30:15], zero
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = srt_pkg::IdW + 2 * srt_pkg::NameW + 1;

   srt_pkg::state_type state_ff, state_in;
   logic [RW-1:0] mem [TABLE_DEPTH];
   logic [RW-1:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [RW-1:0] wr_data;
   logic          rd_en, wr_en;

   logic [1:0]    op_ff, op_in;
   logic [RW-1:0] key_ff, key_in;
   logic [CW-1:0] held_ff, held_in, pos_ff, pos_in;
   logic [15:0]   tally_ff, tally_in;
   logic [1:0]    st_ff, st_in;
   logic [5:0]    slot_ff, slot_in;
   logic          found_ff, found_in;

   logic [srt_pkg::IdW-1:0]   k_id, r_id;
   logic [srt_pkg::NameW-1:0] k_g, k_f, r_g, r_f, keep;
   logic [srt_pkg::NameW-1:0] id_clip;
   logic after;

   assign keep = ~64'd0 << (8 * (8 - NAME_CHARS));
   assign id_clip = srt_pkg::clip_word({16'd0, req_tdata[49:2]}, 6);
   assign k_id = key_ff[RW-1 -: srt_pkg::IdW];
   assign k_g  = key_ff[1 + srt_pkg::NameW +: srt_pkg::NameW];
   assign k_f  = key_ff[1 +: srt_pkg::NameW];
   assign r_id = rd_ff[RW-1 -: srt_pkg::IdW];
   assign r_g  = rd_ff[1 + srt_pkg::NameW +: srt_pkg::NameW];
   assign r_f  = rd_ff[1 +: srt_pkg::NameW];
   assign after = (r_g != k_g) ? (r_g > k_g) : (r_f > k_f);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::S_IDLE;
         held_ff  <= '0;
         tally_ff <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         tally_ff <= tally_in;
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      st_ff    <= st_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; key_in = key_ff; pos_in = pos_ff;
      held_in = held_ff; tally_in = tally_ff;
      st_in = st_ff; slot_in = slot_ff; found_in = found_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = rd_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         srt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_tdata[1:0];
               key_in = {id_clip[srt_pkg::IdW-1:0],
                         srt_pkg::clip_word(req_tdata[113:50] & keep, 8),
                         srt_pkg::clip_word(req_tdata[177:114] & keep, 8),
                         req_tdata[178]};
               st_in = srt_pkg::ST_OK; slot_in = '0; found_in = 1'b0;
               state_in = srt_pkg::S_DONE;
               unique case (srt_pkg::op_type'(req_tdata[1:0]))
                  srt_pkg::OP_INSERT: begin
                     if (held_ff >= CW'(TABLE_DEPTH)) st_in = srt_pkg::ST_FULL;
                     else begin
                        pos_in = held_ff;
                        state_in = srt_pkg::S_READ;
                     end
                  end
                  srt_pkg::OP_REMOVE, srt_pkg::OP_LOOKUP: begin
                     if (held_ff == '0)
                        st_in = (req_tdata[1:0] == srt_pkg::OP_REMOVE) ?
                                srt_pkg::ST_EMPTY : srt_pkg::ST_ABSENT;
                     else begin
                        pos_in = '0;
                        state_in = srt_pkg::S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         srt_pkg::S_READ: begin
            // prime read of first slot of the walk
            rd_en = 1'b1;
            if (op_ff == srt_pkg::OP_INSERT) begin
               if (pos_ff == '0) begin
                  wr_en = 1'b1; wr_addr = '0; wr_data = key_ff;
                  held_in = held_ff + 1'b1; tally_in = tally_ff + 1'b1;
                  state_in = srt_pkg::S_DONE;
               end else begin
                  rd_addr = AW'(pos_ff - 1'b1);
                  state_in = srt_pkg::S_SCAN;
               end
            end else begin
               rd_addr = AW'(pos_ff);
               state_in = srt_pkg::S_SCAN;
            end
         end
         srt_pkg::S_SCAN: begin
            if (op_ff == srt_pkg::OP_INSERT) begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff);
               if (after) begin
                  wr_data = rd_ff;
                  pos_in = pos_ff - 1'b1;
                  if (pos_ff == CW'(1)) begin
                     state_in = srt_pkg::S_READ;
                  end else begin
                     rd_en = 1'b1; rd_addr = AW'(pos_ff - CW'(2));
                  end
               end else begin
                  wr_data = key_ff;
                  held_in = held_ff + 1'b1; tally_in = tally_ff + 1'b1;
                  slot_in = 6'(pos_ff);
                  state_in = srt_pkg::S_DONE;
               end
            end else begin
               // rd_ff holds slot pos_ff
               if (found_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1); wr_data = rd_ff;
               end
               found_in = found_ff;
               if (!found_ff && r_id == k_id) begin
                  found_in = 1'b1;
                  slot_in = 6'(pos_ff);
                  if (op_ff == srt_pkg::OP_LOOKUP) state_in = srt_pkg::S_DONE;
               end
               if (state_in != srt_pkg::S_DONE) begin
                  if (pos_ff + 1'b1 >= held_ff) begin
                     state_in = srt_pkg::S_DONE;
                     if (!found_in) st_in = srt_pkg::ST_ABSENT;
                     else if (op_ff == srt_pkg::OP_REMOVE)
                        held_in = held_ff - 1'b1;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     rd_en = 1'b1; rd_addr = AW'(pos_ff + 1'b1);
                  end
               end
            end
         end
         srt_pkg::S_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = srt_pkg::S_IDLE;
         end
         default: state_in = srt_pkg::S_IDLE;
      endcase
   end

   logic [6:0] cnt7;
   assign cnt7 = 7'(held_ff);
   assign rsp_tdata = {1'b0, tally_ff, cnt7, slot_ff, st_ff};
endmodule

@@ hw/rtl/srt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks of the sorted record table.
// ----------------------------------------------------------------------------
`include "sorted_record_table_assert.svh"
module srt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [183:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata
);
   logic req_fire, rsp_wait, rsp_fail;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign rsp_fail = rsp_tvalid && (rsp_tdata[1:0] != srt_pkg::ST_OK);

   `SRT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_tready, "request while busy")
   `SRT_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "ready while pending")
   `SRT_ASSERT_IMPL(a_fail_slot, clock, reset, rsp_fail, rsp_tdata[7:2] == 6'd0, "failure slot")
   `SRT_ASSERT_NEXT(a_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata), "result dropped")
endmodule

bind sorted_record_table srt_checker u_srt_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted record table: a behavioral copy of the
// sorted stores predicts status, slot and counts for every request; random
// idling on both sides, directed corner requests, fill/drain, random traffic.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int DEPTH = srt_pkg::TableDepthDefault;

   typedef struct packed {
      logic [15:0] issued;
      logic [6:0]  entries;
      logic [5:0]  slot;
      logic [1:0]  status;
   } answer_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [183:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;

   logic [47:0] tab_id[DEPTH];
   logic [63:0] tab_given[DEPTH];
   logic [63:0] tab_family[DEPTH];
   logic        tab_gender[DEPTH];
   int          held;
   logic [15:0] tally;
   answer_type  pending_answers[$];
   int          fail_count;
   bit          busy_idle;  // enables random idling

   sorted_record_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] clip_name(logic [63:0] w, int nbytes);
      logic [63:0] r;
      bit ended;
      r = '0;
      ended = 0;
      for (int k = nbytes - 1; k >= 0; k--) begin
         if (w[8*k +: 8] == 8'd0) ended = 1;
         if (!ended) r[8*k +: 8] = w[8*k +: 8];
      end
      return r;
   endfunction

   function automatic int find_record(logic [47:0] id);
      for (int i = 0; i < held; i++)
         if (tab_id[i] == id) return i;
      return held;
   endfunction

   function automatic answer_type predict_table(srt_pkg::op_type op, logic [47:0] raw_id,
                                                logic [63:0] raw_g, logic [63:0] raw_f,
                                                logic sex);
      answer_type a;
      logic [47:0] id;
      logic [63:0] g, f, wide_id;
      int pos;
      wide_id = clip_name({16'd0, raw_id}, 6);
      id = wide_id[47:0];
      g = clip_name(raw_g, 8);
      f = clip_name(raw_f, 8);
      a = '0;
      a.status = srt_pkg::ST_OK;
      case (op)
         srt_pkg::OP_INSERT: begin
            if (held >= DEPTH) begin
               a.status = srt_pkg::ST_FULL;
            end else begin
               pos = held;
               while (pos > 0 && (tab_given[pos-1] > g ||
                      (tab_given[pos-1] == g && tab_family[pos-1] > f))) begin
                  tab_id[pos] = tab_id[pos-1];
                  tab_given[pos] = tab_given[pos-1];
                  tab_family[pos] = tab_family[pos-1];
                  tab_gender[pos] = tab_gender[pos-1];
                  pos--;
               end
               tab_id[pos] = id;
               tab_given[pos] = g;
               tab_family[pos] = f;
               tab_gender[pos] = sex;
               held++;
               tally++;
               a.slot = pos[5:0];
            end
         end
         srt_pkg::OP_REMOVE: begin
            if (held == 0) begin
               a.status = srt_pkg::ST_EMPTY;
            end else begin
               pos = find_record(id);
               if (pos >= held) begin
                  a.status = srt_pkg::ST_ABSENT;
               end else begin
                  for (int i = pos; i + 1 < held; i++) begin
                     tab_id[i] = tab_id[i+1];
                     tab_given[i] = tab_given[i+1];
                     tab_family[i] = tab_family[i+1];
                     tab_gender[i] = tab_gender[i+1];
                  end
                  held--;
                  a.slot = pos[5:0];
               end
            end
         end
         srt_pkg::OP_LOOKUP: begin
            pos = find_record(id);
            if (pos >= held) a.status = srt_pkg::ST_ABSENT;
            else a.slot = pos[5:0];
         end
         default: ;
      endcase
      a.entries = held[6:0];
      a.issued = tally;
      return a;
   endfunction

   // valid stays up after an accept until the next request or a drain
   task automatic send_request(srt_pkg::op_type op, logic [47:0] id, logic [63:0] g,
                               logic [63:0] f, logic sex);
      if (busy_idle && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (busy_idle && $urandom_range(99) < 19) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, sex, f, g, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(predict_table(op, id, g, f, sex));
   endtask

   // rsp side: random stall, then check against oldest expectation
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[30:0];
            if (pending_answers.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot expected %0d actual %0d", want.slot, got.slot);
                  fail_count++;
               end
               if (got.entries !== want.entries) begin
                  $error("entry_count expected %0d actual %0d", want.entries,
                         got.entries);
                  fail_count++;
               end
               if (got.issued !== want.issued) begin
                  $error("issued_count expected %0d actual %0d", want.issued,
                         got.issued);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !(busy_idle && $urandom_range(99) < 19);
      end
   end

   function automatic logic [63:0] random_name();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(3))
         0: w = {8'h41 + 8'($urandom_range(2)), 56'd0};
         1: w[8*$urandom_range(7) +: 8] = 8'd0;
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [47:0] random_id();
      logic [47:0] w;
      w = {8'h49, 32'd0, 8'h30 + 8'($urandom_range(40))};
      if ($urandom_range(9) == 0) w = 48'({$urandom, $urandom});
      else if ($urandom_range(9) == 0) w[8*$urandom_range(5) +: 8] = 8'd0;
      return w;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(srt_pkg::OP_REMOVE, 48'h49_0000_0000_31, '0, '0, 1'b0);
      send_request(srt_pkg::OP_LOOKUP, 48'h49_0000_0000_31, '0, '0, 1'b0);
      send_request(srt_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, '1, '1, 1'b1);
      send_request(srt_pkg::OP_INSERT, 48'h0, '0, '0, 1'b0);
      send_request(srt_pkg::OP_INSERT, 48'h49_00FF_0000_31, 64'h4100_FFFF_FFFF_FFFF,
                   64'h4200_1234_0000_0000, 1'b1);
      send_request(srt_pkg::OP_INSERT, 48'h49_0000_0000_32, 64'h4100_0000_0000_0000,
                   64'h4200_0000_0000_0000, 1'b0);
      send_request(srt_pkg::OP_LOOKUP, 48'h49_0000_0000_32, '0, '0, 1'b0);
      send_request(srt_pkg::OP_LOOKUP, 48'h49_0000_0000_31, '0, '0, 1'b0);
      send_request(srt_pkg::OP_NONE, '1, '1, '1, 1'b1);
      send_request(srt_pkg::OP_REMOVE, 48'h49_0000_0000_31, '0, '0, 1'b0);
      send_request(srt_pkg::OP_REMOVE, 48'h55_5555_5555_55, '0, '0, 1'b0);
      send_request(srt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0);
      send_request(srt_pkg::OP_REMOVE, 48'h0, '0, '0, 1'b0);
   endtask

   task automatic test_fill_and_drain();
      // run to full, try overflow, then empty out and remove once more
      while (held < DEPTH)
         send_request(srt_pkg::OP_INSERT, random_id(), random_name(), random_name(),
                      1'($urandom));
      send_request(srt_pkg::OP_INSERT, random_id(), random_name(), random_name(), 1'b1);
      wait_drained();
      while (held > 0) send_request(srt_pkg::OP_REMOVE, tab_id[$urandom_range(held - 1)],
                                    '0, '0, 1'b0);
      send_request(srt_pkg::OP_REMOVE, random_id(), '0, '0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int pick;
      srt_pkg::op_type op;
      for (int n = 0; n < 1350; n++) begin
         busy_idle = !(n >= 400 && n < 600);
         pick = $urandom_range(99);
         if (pick < 45) op = srt_pkg::OP_INSERT;
         else if (pick < 75) op = srt_pkg::OP_REMOVE;
         else if (pick < 97) op = srt_pkg::OP_LOOKUP;
         else op = srt_pkg::OP_NONE;
         if (op != srt_pkg::OP_INSERT && held > 0 && $urandom_range(2) != 0)
            send_request(op, tab_id[$urandom_range(held - 1)], random_name(),
                         random_name(), 1'($urandom));
         else
            send_request(op, random_id(), random_name(), random_name(),
                         1'($urandom));
         if (n == 900) wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      held = 0;
      tally = '0;
      fail_count = 0;
      busy_idle = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random_traffic();
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/srt_pkg.sv
hw/rtl/sorted_record_table.sv
hw/rtl/srt_checker.sv
tb/tb_top.sv
